[rtl/alr_pkg.sv]
// ============================================================================
// alr_pkg: shared constants and types of the antialiased line rasterizer
// Widths of the line arithmetic, register codes, and the command and status
// bundles that pass between the controller and the datapath.
// ============================================================================
package alr_pkg;

  // Line arithmetic
  localparam int COORD_BITS = 16;                    // endpoint coordinate width
  localparam int FRAC_BITS  = 16;                    // fraction bits of slope and row
  localparam int PW         = COORD_BITS + 2;        // signed pixel coordinate in line space
  localparam int ACC_W      = COORD_BITS + FRAC_BITS + 2;  // row accumulator
  localparam int SLOPE_W    = FRAC_BITS + 2;         // |slope| <= 1.0
  localparam int WGT_W      = FRAC_BITS + 1;         // weight 0 .. 1.0
  localparam int DIV_W      = COORD_BITS + FRAC_BITS;  // dividend of the slope divide
  localparam int DIV_CNT_W  = $clog2(DIV_W);
  localparam int CLIP_W     = (PW > 14) ? PW : 14;   // compare width for clipping

  localparam logic [WGT_W-1:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // Field and register widths
  localparam int SCR_W      = 13;
  localparam int STRIDE_W   = 15;
  localparam int BPP_W      = 6;
  localparam int COLOR_W    = 24;
  localparam int CH_W       = 8;
  localparam int PIX_W      = 12;
  localparam int OFS_W      = 26;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [SCR_W-1:0] SCREEN_MAX = SCR_W'(4096);

  // Operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_BITS_PER_PIX  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK      = CFG_IDX_W'(4);

  // Register reset values
  localparam logic [SCR_W-1:0]    RST_SCREEN_WIDTH  = SCR_W'(1920);
  localparam logic [SCR_W-1:0]    RST_SCREEN_HEIGHT = SCR_W'(1080);
  localparam logic [STRIDE_W-1:0] RST_ROW_STRIDE    = STRIDE_W'(7680);
  localparam logic [BPP_W-1:0]    RST_BITS_PER_PIX  = BPP_W'(32);
  localparam logic [COLOR_W-1:0]  RST_FALLBACK      = 24'hFF7F00;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture a start item
    logic swap;       // decide steepness, swap axes
    logic order;      // order endpoints along the major axis
    logic emit;       // load the output register with a candidate
    logic sel;        // candidate 0 or 1
    logic last;       // final transfer of this item
    logic step_mode;  // candidates come from the stepping state
    logic div_start;  // launch the slope divide
    logic finish;     // commit slope and stepping state
    logic advance;    // move one column
  } alr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic busy;       // a line is being stepped
    logic vis0;       // candidate 0 lands on screen with nonzero weight
    logic vis1;       // candidate 1 likewise
    logic single;     // the line is a single point
    logic out_free;   // output register can take a pixel
    logic div_done;   // slope quotient ready
  } alr_sts_t;

endpackage

[rtl/alr_in_if.sv]
// ============================================================================
// alr_in_if: input item channel
// Valid/ready channel carrying one start or step item.
// ============================================================================
interface alr_in_if;
  logic                                valid;
  logic                                ready;
  logic                                op;
  logic signed [alr_pkg::COORD_BITS-1:0] start_x;
  logic signed [alr_pkg::COORD_BITS-1:0] start_y;
  logic [alr_pkg::COLOR_W-1:0]         start_color;
  logic signed [alr_pkg::COORD_BITS-1:0] end_x;
  logic signed [alr_pkg::COORD_BITS-1:0] end_y;
  logic [alr_pkg::COLOR_W-1:0]         end_color;

  modport source (
    output valid, op, start_x, start_y, start_color, end_x, end_y, end_color,
    input  ready
  );
  modport sink (
    input  valid, op, start_x, start_y, start_color, end_x, end_y, end_color,
    output ready
  );
endinterface

[rtl/alr_out_if.sv]
// ============================================================================
// alr_out_if: pixel result channel
// Valid/ready channel carrying one weighted pixel write.
// ============================================================================
interface alr_out_if;
  logic                        valid;
  logic                        ready;
  logic [alr_pkg::PIX_W-1:0]   pixel_x;
  logic [alr_pkg::PIX_W-1:0]   pixel_y;
  logic [alr_pkg::OFS_W-1:0]   byte_offset;
  logic [alr_pkg::CH_W-1:0]    blue;
  logic [alr_pkg::CH_W-1:0]    green;
  logic [alr_pkg::CH_W-1:0]    red;
  logic                        last;
  logic                        line_done;

  modport source (
    output valid, pixel_x, pixel_y, byte_offset, blue, green, red, last, line_done,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, byte_offset, blue, green, red, last, line_done,
    output ready
  );
endinterface

[rtl/antialiased_line_rasterizer_unit.sv]
// ============================================================================
// antialiased_line_rasterizer_unit: Wu-style antialiased line generator
// Start items emit the two endpoints and set up a fixed-point slope; step
// items emit up to two weighted pixels per column.
// ============================================================================
// Step item: the candidate pixels are loaded in S_EMIT0 and S_EMIT1, one per
//   cycle while the output is free; the next item is taken after S_EMIT1.
// Start item: the item passes S_SWAP and S_ORDER before the first endpoint is
//   loaded. The next item waits for the restoring slope divider (a single point
//   skips it), one quotient bit per cycle over 32 bits, and output stalls delay it.
// Reset is asynchronous: registers return to their defaults, no line is active.
module antialiased_line_rasterizer_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [alr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [alr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  alr_in_if.sink                         in_if,
  alr_out_if.source                      out_if
);

  alr_pkg::alr_cmd_t cmd;
  alr_pkg::alr_sts_t sts;

  // Sequencer
  alr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_op_i    (in_if.op),
    .in_ready_o (in_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath
  alr_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_start_x_i      (in_if.start_x),
    .in_start_y_i      (in_if.start_y),
    .in_start_color_i  (in_if.start_color),
    .in_end_x_i        (in_if.end_x),
    .in_end_y_i        (in_if.end_y),
    .in_end_color_i    (in_if.end_color),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_valid_o       (out_if.valid),
    .out_ready_i       (out_if.ready),
    .out_pixel_x_o     (out_if.pixel_x),
    .out_pixel_y_o     (out_if.pixel_y),
    .out_byte_offset_o (out_if.byte_offset),
    .out_blue_o        (out_if.blue),
    .out_green_o       (out_if.green),
    .out_red_o         (out_if.red),
    .out_last_o        (out_if.last),
    .out_line_done_o   (out_if.line_done)
  );

endmodule

[rtl/alr_ctrl.sv]
// ============================================================================
// alr_ctrl: sequencer of the antialiased line rasterizer
// Takes items, walks a start through swap, order, endpoint emission and the
// slope divide, and a step through its two candidate pixels.
// ============================================================================
module alr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_op_i,
  output logic              in_ready_o,
  input  alr_pkg::alr_sts_t sts_i,
  output alr_pkg::alr_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWAP,
    S_ORDER,
    S_EMIT0,
    S_EMIT1,
    S_DIV
  } state_e;

  state_e state_q, state_d;
  logic   mode_q, mode_d;   // 1: stepping item, 0: start item

  // Next state and commands
  always_comb begin
    state_d         = state_q;
    mode_d          = mode_q;
    cmd_o           = '0;
    cmd_o.step_mode = mode_q;
    in_ready_o      = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_op_i == alr_pkg::OP_START) begin
            cmd_o.load = 1'b1;
            mode_d     = 1'b0;
            state_d    = S_SWAP;
          end else if (sts_i.busy) begin
            mode_d  = 1'b1;
            state_d = S_EMIT0;
          end
        end
      end
      S_SWAP: begin
        cmd_o.swap = 1'b1;
        state_d    = S_ORDER;
      end
      S_ORDER: begin
        cmd_o.order = 1'b1;
        state_d     = S_EMIT0;
      end
      S_EMIT0: begin
        if (!sts_i.vis0) begin
          state_d = S_EMIT1;
        end else if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = 1'b0;
          cmd_o.last = !sts_i.vis1;
          state_d    = S_EMIT1;
        end
      end
      S_EMIT1: begin
        if (!sts_i.vis1 || sts_i.out_free) begin
          cmd_o.emit = sts_i.vis1;
          cmd_o.sel  = 1'b1;
          cmd_o.last = 1'b1;
          if (mode_q) begin
            cmd_o.advance = 1'b1;
            state_d       = S_IDLE;
          end else if (sts_i.single) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.div_start = 1'b1;
            state_d         = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
    end
  end

endmodule

[rtl/alr_div.sv]
// ============================================================================
// alr_div: restoring divider for the line slope
// Unsigned divide, one quotient bit per cycle; done pulses for one cycle.
// ============================================================================
module alr_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [alr_pkg::DIV_W-1:0]        dividend_i,
  input  logic [alr_pkg::COORD_BITS-1:0]   divisor_i,
  output logic                             done_o,
  output logic [alr_pkg::DIV_W-1:0]        quotient_o
);

  logic                                busy_q;
  logic                                done_q;
  logic [alr_pkg::DIV_CNT_W-1:0]       cnt_q;
  logic [alr_pkg::COORD_BITS-1:0]      rem_q;
  logic [alr_pkg::COORD_BITS-1:0]      dvs_q;
  logic [alr_pkg::DIV_W-1:0]           quo_q;

  logic [alr_pkg::COORD_BITS:0]        trial;
  logic [alr_pkg::COORD_BITS:0]        diff;
  logic                                fits;
  logic [alr_pkg::COORD_BITS-1:0]      rem_next;

  // One restoring step: shift in the next dividend bit, try the subtract
  assign trial    = {rem_q, quo_q[alr_pkg::DIV_W-1]};
  assign diff     = trial - {1'b0, dvs_q};
  assign fits     = trial >= {1'b0, dvs_q};
  assign rem_next = fits ? diff[alr_pkg::COORD_BITS-1:0] : trial[alr_pkg::COORD_BITS-1:0];

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= alr_pkg::DIV_CNT_W'(alr_pkg::DIV_W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - alr_pkg::DIV_CNT_W'(1);
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Remainder and quotient shifter; dividend bits leave as quotient bits enter
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_next;
      quo_q <= {quo_q[alr_pkg::DIV_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[rtl/alr_datapath.sv]
// ============================================================================
// alr_datapath: line state, pixel candidates and output register
// Holds the registers, orders the endpoints, steps the fixed-point row,
// clips and weights the two candidate pixels and computes byte offsets.
// ============================================================================
module alr_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration writes
  input  logic                                  cfg_we_i,
  input  logic [alr_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [alr_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  // start item payload
  input  logic signed [alr_pkg::COORD_BITS-1:0] in_start_x_i,
  input  logic signed [alr_pkg::COORD_BITS-1:0] in_start_y_i,
  input  logic [alr_pkg::COLOR_W-1:0]           in_start_color_i,
  input  logic signed [alr_pkg::COORD_BITS-1:0] in_end_x_i,
  input  logic signed [alr_pkg::COORD_BITS-1:0] in_end_y_i,
  input  logic [alr_pkg::COLOR_W-1:0]           in_end_color_i,
  // sequencer
  input  alr_pkg::alr_cmd_t                     cmd_i,
  output alr_pkg::alr_sts_t                     sts_o,
  // pixel channel
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [alr_pkg::PIX_W-1:0]             out_pixel_x_o,
  output logic [alr_pkg::PIX_W-1:0]             out_pixel_y_o,
  output logic [alr_pkg::OFS_W-1:0]             out_byte_offset_o,
  output logic [alr_pkg::CH_W-1:0]              out_blue_o,
  output logic [alr_pkg::CH_W-1:0]              out_green_o,
  output logic [alr_pkg::CH_W-1:0]              out_red_o,
  output logic                                  out_last_o,
  output logic                                  out_line_done_o
);

  localparam int C  = alr_pkg::COORD_BITS;
  localparam int F  = alr_pkg::FRAC_BITS;
  localparam int PW = alr_pkg::PW;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [alr_pkg::SCR_W-1:0]    width_q, height_q;
  logic [alr_pkg::STRIDE_W-1:0] stride_q;
  logic [alr_pkg::BPP_W-1:0]    bpp_q;
  logic [alr_pkg::COLOR_W-1:0]  fallback_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= alr_pkg::RST_SCREEN_WIDTH;
      height_q   <= alr_pkg::RST_SCREEN_HEIGHT;
      stride_q   <= alr_pkg::RST_ROW_STRIDE;
      bpp_q      <= alr_pkg::RST_BITS_PER_PIX;
      fallback_q <= alr_pkg::RST_FALLBACK;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        alr_pkg::CFG_SCREEN_WIDTH:  width_q    <= cfg_data_i[alr_pkg::SCR_W-1:0];
        alr_pkg::CFG_SCREEN_HEIGHT: height_q   <= cfg_data_i[alr_pkg::SCR_W-1:0];
        alr_pkg::CFG_ROW_STRIDE:    stride_q   <= cfg_data_i[alr_pkg::STRIDE_W-1:0];
        alr_pkg::CFG_BITS_PER_PIX:  bpp_q      <= cfg_data_i[alr_pkg::BPP_W-1:0];
        alr_pkg::CFG_FALLBACK:      fallback_q <= cfg_data_i[alr_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Clip bounds saturate at the addressable screen size
  logic [alr_pkg::SCR_W-1:0] bound_w, bound_h;
  assign bound_w = (width_q  > alr_pkg::SCREEN_MAX) ? alr_pkg::SCREEN_MAX : width_q;
  assign bound_h = (height_q > alr_pkg::SCREEN_MAX) ? alr_pkg::SCREEN_MAX : height_q;

  // --------------------------------------------------------------------------
  // Start item capture; zero colors take the fallback
  // --------------------------------------------------------------------------
  logic signed [C-1:0]          rx1_q, ry1_q, rx2_q, ry2_q;
  logic [alr_pkg::COLOR_W-1:0]  c1_q, c2_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rx1_q <= in_start_x_i;
      ry1_q <= in_start_y_i;
      rx2_q <= in_end_x_i;
      ry2_q <= in_end_y_i;
      c1_q  <= (in_start_color_i == '0) ? fallback_q : in_start_color_i;
      c2_q  <= (in_end_color_i   == '0) ? fallback_q : in_end_color_i;
    end
  end

  // --------------------------------------------------------------------------
  // Steepness and axis swap
  // --------------------------------------------------------------------------
  logic signed [C:0]   ddx, ddy, ndx, ndy;
  logic [C-1:0]        adx, ady;
  logic                steep_d, steep_q;
  logic signed [C-1:0] a1_q, b1_q, a2_q, b2_q;

  assign ddx     = {rx2_q[C-1], rx2_q} - {rx1_q[C-1], rx1_q};
  assign ddy     = {ry2_q[C-1], ry2_q} - {ry1_q[C-1], ry1_q};
  assign ndx     = -ddx;
  assign ndy     = -ddy;
  assign adx     = ddx[C] ? ndx[C-1:0] : ddx[C-1:0];
  assign ady     = ddy[C] ? ndy[C-1:0] : ddy[C-1:0];
  assign steep_d = ady > adx;

  always_ff @(posedge clk_i) begin
    if (cmd_i.swap) begin
      a1_q <= steep_d ? ry1_q : rx1_q;
      b1_q <= steep_d ? rx1_q : ry1_q;
      a2_q <= steep_d ? ry2_q : rx2_q;
      b2_q <= steep_d ? rx2_q : ry2_q;
    end
  end

  // --------------------------------------------------------------------------
  // Endpoint ordering along the major axis
  // --------------------------------------------------------------------------
  logic                swap_ends;
  logic signed [C-1:0] ox1_q, oy1_q, ox2_q, oy2_q;

  assign swap_ends = a1_q > a2_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.order) begin
      ox1_q <= swap_ends ? a2_q : a1_q;
      oy1_q <= swap_ends ? b2_q : b1_q;
      ox2_q <= swap_ends ? a1_q : a2_q;
      oy2_q <= swap_ends ? b1_q : b2_q;
    end
  end

  // Extents of the ordered line; |dy| never exceeds dx
  logic [C-1:0]        dx, ady_o;
  logic signed [C:0]   dy, ndy_o;
  logic                single;

  assign dx     = ox2_q - ox1_q;
  assign dy     = {oy2_q[C-1], oy2_q} - {oy1_q[C-1], oy1_q};
  assign ndy_o  = -dy;
  assign ady_o  = dy[C] ? ndy_o[C-1:0] : dy[C-1:0];
  assign single = dx == '0;

  // --------------------------------------------------------------------------
  // Slope divide
  // --------------------------------------------------------------------------
  logic                      div_done;
  logic [alr_pkg::DIV_W-1:0] div_q;

  alr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i ({ady_o, {F{1'b0}}}),
    .divisor_i  (dx),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  // Signed slope, truncated toward zero, and the first stepped row
  logic signed [alr_pkg::SLOPE_W-1:0] slope_mag, slope_new;
  logic signed [alr_pkg::ACC_W-1:0]   accum_new;

  assign slope_mag = {1'b0, div_q[F:0]};
  assign slope_new = dy[C] ? -slope_mag : slope_mag;
  assign accum_new = {{(alr_pkg::ACC_W-C-F){oy1_q[C-1]}}, oy1_q, {F{1'b0}}}
                   + {{(alr_pkg::ACC_W-alr_pkg::SLOPE_W){slope_new[alr_pkg::SLOPE_W-1]}},
                      slope_new};

  // --------------------------------------------------------------------------
  // Stepping state
  // --------------------------------------------------------------------------
  logic                               busy_q;
  logic signed [alr_pkg::ACC_W-1:0]   accum_q;
  logic signed [alr_pkg::SLOPE_W-1:0] slope_q;
  logic signed [PW-1:0]               column_q;
  logic signed [C-1:0]                last_col_q;
  logic [alr_pkg::COLOR_W-1:0]        line_color_q;
  logic signed [PW-1:0]               last_col_ext;
  logic                               step_done;

  assign last_col_ext = {{(PW-C){last_col_q[C-1]}}, last_col_q};
  assign step_done    = column_q >= last_col_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      steep_q      <= 1'b0;
      accum_q      <= '0;
      slope_q      <= '0;
      column_q     <= '0;
      last_col_q   <= '0;
      line_color_q <= '0;
    end else begin
      if (cmd_i.load) begin
        busy_q <= 1'b0;
      end
      if (cmd_i.swap) begin
        steep_q <= steep_d;
      end
      if (cmd_i.finish) begin
        busy_q       <= 1'b1;
        slope_q      <= slope_new;
        accum_q      <= accum_new;
        column_q     <= {{(PW-C){ox1_q[C-1]}}, ox1_q} + PW'(1);
        last_col_q   <= ox2_q;
        line_color_q <= c2_q;
      end
      if (cmd_i.advance) begin
        accum_q  <= accum_q + {{(alr_pkg::ACC_W-alr_pkg::SLOPE_W){slope_q[alr_pkg::SLOPE_W-1]}},
                               slope_q};
        column_q <= column_q + PW'(1);
        if (step_done) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Candidate pixels: the two endpoints, or the two rows straddling the line
  // --------------------------------------------------------------------------
  logic [F-1:0]                 frac;
  logic signed [PW-1:0]         row_lo, row_hi;
  logic signed [PW-1:0]         a0, b0, a1, b1;
  logic signed [PW-1:0]         sx0, sy0, sx1, sy1;
  logic [alr_pkg::WGT_W-1:0]    w0, w1;
  logic [alr_pkg::COLOR_W-1:0]  col0, col1;
  logic                         done_flag;
  logic                         vis0, vis1;

  assign frac   = accum_q[F-1:0];
  assign row_lo = accum_q[alr_pkg::ACC_W-1:F];
  assign row_hi = row_lo + PW'(1);

  assign a0 = cmd_i.step_mode ? column_q : {{(PW-C){ox1_q[C-1]}}, ox1_q};
  assign b0 = cmd_i.step_mode ? row_lo   : {{(PW-C){oy1_q[C-1]}}, oy1_q};
  assign a1 = cmd_i.step_mode ? column_q : {{(PW-C){ox2_q[C-1]}}, ox2_q};
  assign b1 = cmd_i.step_mode ? row_hi   : {{(PW-C){oy2_q[C-1]}}, oy2_q};

  assign w0 = cmd_i.step_mode ? alr_pkg::FRAC_ONE - {1'b0, frac} : alr_pkg::FRAC_ONE;
  assign w1 = cmd_i.step_mode ? {1'b0, frac} : alr_pkg::FRAC_ONE;

  assign col0      = cmd_i.step_mode ? line_color_q : c1_q;
  assign col1      = cmd_i.step_mode ? line_color_q : c2_q;
  assign done_flag = cmd_i.step_mode ? step_done : single;

  // Back to screen axes
  assign sx0 = steep_q ? b0 : a0;
  assign sy0 = steep_q ? a0 : b0;
  assign sx1 = steep_q ? b1 : a1;
  assign sy1 = steep_q ? a1 : b1;

  function automatic logic on_screen(input logic signed [PW-1:0]     x,
                                     input logic signed [PW-1:0]     y,
                                     input logic [alr_pkg::SCR_W-1:0] bw,
                                     input logic [alr_pkg::SCR_W-1:0] bh);
    logic [alr_pkg::CLIP_W-1:0] xe, ye;
    xe = alr_pkg::CLIP_W'(x);
    ye = alr_pkg::CLIP_W'(y);
    return !x[PW-1] && !y[PW-1] &&
           (xe < alr_pkg::CLIP_W'(bw)) && (ye < alr_pkg::CLIP_W'(bh));
  endfunction

  assign vis0 = on_screen(sx0, sy0, bound_w, bound_h) && (w0 != '0);
  assign vis1 = on_screen(sx1, sy1, bound_w, bound_h) && (w1 != '0);

  // --------------------------------------------------------------------------
  // Selected pixel: address and weighted channels
  // --------------------------------------------------------------------------
  function automatic logic [alr_pkg::CH_W-1:0] scale(input logic [alr_pkg::CH_W-1:0]  ch,
                                                     input logic [alr_pkg::WGT_W-1:0] w);
    logic [alr_pkg::CH_W+alr_pkg::WGT_W-1:0] p;
    p = (alr_pkg::CH_W+alr_pkg::WGT_W)'(ch) * (alr_pkg::CH_W+alr_pkg::WGT_W)'(w);
    return p[F +: alr_pkg::CH_W];
  endfunction

  localparam int ROW_W = alr_pkg::PIX_W + alr_pkg::STRIDE_W;

  logic [alr_pkg::PIX_W-1:0]   px, py;
  logic [alr_pkg::WGT_W-1:0]   w_sel;
  logic [alr_pkg::COLOR_W-1:0] col_sel;
  logic [2:0]                  bytes_pp;
  logic [ROW_W-1:0]            ofs_row, ofs_col, ofs_sum;

  assign px       = cmd_i.sel ? sx1[alr_pkg::PIX_W-1:0] : sx0[alr_pkg::PIX_W-1:0];
  assign py       = cmd_i.sel ? sy1[alr_pkg::PIX_W-1:0] : sy0[alr_pkg::PIX_W-1:0];
  assign w_sel    = cmd_i.sel ? w1 : w0;
  assign col_sel  = cmd_i.sel ? col1 : col0;
  assign bytes_pp = bpp_q[alr_pkg::BPP_W-1:3];
  assign ofs_row  = ROW_W'(py) * ROW_W'(stride_q);
  assign ofs_col  = ROW_W'(px) * ROW_W'(bytes_pp);
  assign ofs_sum  = ofs_row + ofs_col;

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic out_valid_q;
  logic out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_pixel_x_o     <= px;
      out_pixel_y_o     <= py;
      out_byte_offset_o <= ofs_sum[alr_pkg::OFS_W-1:0];
      out_blue_o        <= scale(col_sel[7:0],   w_sel);
      out_green_o       <= scale(col_sel[15:8],  w_sel);
      out_red_o         <= scale(col_sel[23:16], w_sel);
      out_last_o        <= cmd_i.last;
      out_line_done_o   <= done_flag;
    end
  end

  assign out_valid_o = out_valid_q;

  // Status back to the sequencer
  assign sts_o.busy     = busy_q;
  assign sts_o.vis0     = vis0;
  assign sts_o.vis1     = vis1;
  assign sts_o.single   = single;
  assign sts_o.out_free = out_free;
  assign sts_o.div_done = div_done;

`ifndef SYNTHESIS
  // A pixel is only loaded when the output register can take it
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free)
    else $error("pixel loaded while output register still held");

  // The slope divide never starts on a single-point line
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> (dx != '0))
    else $error("slope divide started with zero divisor");

  // The major axis guarantees |slope| <= 1.0
  a_slope_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> (div_q <= alr_pkg::DIV_W'(alr_pkg::FRAC_ONE)))
    else $error("slope quotient above one");

  // Stepping begins only when a slope has been committed
  a_busy_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |-> $past(cmd_i.finish))
    else $error("line became active without a committed slope");
`endif

endmodule

[sim/antialiased_line_rasterizer_unit_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// antialiased_line_rasterizer_unit_tb: self-checking bench for the Wu line unit
// Drives start and step items through the input channel, predicts every pixel
// write with its own fixed-point line tracer and checks each output transfer
// field by field. A directed table runs first, then random lines over several
// screen setups with random idle bursts on both channels.
// ============================================================================
module antialiased_line_rasterizer_unit_tb;

  localparam int     DIR_ROWS      = 25;
  localparam int     PHASES        = 10;
  localparam int     SETTLE_CYCLES = 64;     // covers a start that emits nothing
  localparam int     LONG_HOLD     = 300;
  localparam int     IDLE_LIMIT    = 4000;
  localparam longint UNIT_WEIGHT   = longint'(1) << alr_pkg::FRAC_BITS;

  typedef struct packed {
    logic                           op;
    logic [alr_pkg::COORD_BITS-1:0] sx;
    logic [alr_pkg::COORD_BITS-1:0] sy;
    logic [alr_pkg::COLOR_W-1:0]    sc;
    logic [alr_pkg::COORD_BITS-1:0] ex;
    logic [alr_pkg::COORD_BITS-1:0] ey;
    logic [alr_pkg::COLOR_W-1:0]    ec;
  } line_item_t;

  typedef struct packed {
    logic [alr_pkg::PIX_W-1:0] px;
    logic [alr_pkg::PIX_W-1:0] py;
    logic [alr_pkg::OFS_W-1:0] ofs;
    logic [alr_pkg::CH_W-1:0]  b;
    logic [alr_pkg::CH_W-1:0]  g;
    logic [alr_pkg::CH_W-1:0]  r;
    logic                      last;
    logic                      done;
  } pixel_t;

  typedef struct packed {
    line_item_t it;
    logic       chk;
    pixel_t     want;   // first pixel of the item, when chk is set
  } dir_row_t;

  // Directed table: corner cases first, expected first pixel typed in where obvious
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // step with no line running: dropped
    '{'{alr_pkg::OP_STEP, 16'h7FFF, 16'h8000, 24'hFFFFFF, 16'h8000, 16'h7FFF, 24'h000000},
      1'b0, '0},
    // single point at the origin, drawn twice
    '{'{alr_pkg::OP_START, 16'd0, 16'd0, 24'h123456, 16'd0, 16'd0, 24'h123456}, 1'b1,
      '{12'd0, 12'd0, 26'd0, 8'h56, 8'h34, 8'h12, 1'b0, 1'b1}},
    // single point in the far corner, zero colour takes the fallback
    '{'{alr_pkg::OP_START, 16'd1919, 16'd1079, 24'h000000, 16'd1919, 16'd1079, 24'hABCDEF},
      1'b1, '{12'd1919, 12'd1079, 26'd8294396, 8'h00, 8'h7F, 8'hFF, 1'b0, 1'b1}},
    // single point off screen
    '{'{alr_pkg::OP_START, 16'hFFFF, 16'hFFFF, 24'h0000FF, 16'hFFFF, 16'hFFFF, 24'h0000FF},
      1'b0, '0},
    // horizontal line, four columns to step
    '{'{alr_pkg::OP_START, 16'd10, 16'd20, 24'hFFFFFF, 16'd14, 16'd20, 24'h0000FF}, 1'b1,
      '{12'd10, 12'd20, 26'd153640, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0}},
    '{'{alr_pkg::OP_STEP, 16'd0, 16'd0, 24'h0, 16'd0, 16'd0, 24'h0}, 1'b0, '0},
    '{'{alr_pkg::OP_STEP, 16'd0, 16'd0, 24'h0, 16'd0, 16'd0, 24'h0}, 1'b0, '0},
    '{'{alr_pkg::OP_STEP, 16'd0, 16'd0, 24'h0, 16'd0, 16'd0, 24'h0}, 1'b0, '0},
    '{'{alr_pkg::OP_STEP, 16'd0, 16'd0, 24'h0, 16'd0, 16'd0, 24'h0}, 1'b0, '0},
    // one step past the end: dropped
    '{'{alr_pkg::OP_STEP, 16'd0, 16'd0, 24'h0, 16'd0, 16'd0, 24'h0}, 1'b0, '0},
    // steep line, axes swapped, fallback on the far end
    '{'{alr_pkg::OP_START, 16'd5, 16'd5, 24'h00FF00, 16'd8, 16'd30, 24'h000000}, 1'b0, '0},
    '{'{alr_pkg::OP_STEP, 16'd0, 16'd0, 24'h0, 16'd0, 16'd0, 24'h0}, 1'b0, '0},
    '{'{alr_pkg::OP_STEP, 16'd0, 16'd0, 24'h0, 16'd0, 16'd0, 24'h0}, 1'b0, '0},
    '{'{alr_pkg::OP_STEP, 16'd0, 16'd0, 24'h0, 16'd0, 16'd0, 24'h0}, 1'b0, '0},
    // endpoints given right to left
    '{'{alr_pkg::OP_START, 16'd100, 16'd50, 24'h808080, 16'd90, 16'd47, 24'h102030},
      1'b0, '0},
    '{'{alr_pkg::OP_STEP, 16'd0, 16'd0, 24'h0, 16'd0, 16'd0, 24'h0}, 1'b0, '0},
    '{'{alr_pkg::OP_STEP, 16'd0, 16'd0, 24'h0, 16'd0, 16'd0, 24'h0}, 1'b0, '0},
    // new line while busy, negative slope truncated toward zero
    '{'{alr_pkg::OP_START, 16'd0, 16'd10, 24'hFFFFFF, 16'd3, 16'd8, 24'hFFFFFF}, 1'b0, '0},
    '{'{alr_pkg::OP_STEP, 16'd0, 16'd0, 24'h0, 16'd0, 16'd0, 24'h0}, 1'b0, '0},
    '{'{alr_pkg::OP_STEP, 16'd0, 16'd0, 24'h0, 16'd0, 16'd0, 24'h0}, 1'b0, '0},
    '{'{alr_pkg::OP_STEP, 16'd0, 16'd0, 24'h0, 16'd0, 16'd0, 24'h0}, 1'b0, '0},
    // coordinate extremes
    '{'{alr_pkg::OP_START, 16'h8000, 16'h8000, 24'h800000, 16'h7FFF, 16'h7FFF, 24'h7FFFFF},
      1'b0, '0},
    '{'{alr_pkg::OP_STEP, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF},
      1'b0, '0},
    '{'{alr_pkg::OP_START, 16'h7FFF, 16'h8000, 24'hFFFFFF, 16'h8000, 16'h7FFF, 24'h000001},
      1'b0, '0},
    '{'{alr_pkg::OP_STEP, 16'd0, 16'd0, 24'h0, 16'd0, 16'd0, 24'h0}, 1'b0, '0}
  };

  logic                           clk_i      = 1'b0;
  logic                           rst_ni     = 1'b0;
  logic                           cfg_we_i   = 1'b0;
  logic [alr_pkg::CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [alr_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  alr_in_if  in_bus ();
  alr_out_if out_bus ();

  antialiased_line_rasterizer_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_bus),
    .out_if     (out_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Line tracer state and its copy of the registers
  logic [alr_pkg::SCR_W-1:0]    scr_w;
  logic [alr_pkg::SCR_W-1:0]    scr_h;
  logic [alr_pkg::STRIDE_W-1:0] row_stride;
  logic [alr_pkg::BPP_W-1:0]    pix_bits;
  logic [alr_pkg::COLOR_W-1:0]  fallback;
  bit                           ln_busy;
  bit                           ln_steep;
  longint                       ln_col;
  longint                       ln_last_col;
  longint                       ln_row;
  longint                       ln_slope;
  logic [alr_pkg::COLOR_W-1:0]  ln_color;

  pixel_t expected_pixels[$];
  pixel_t item_pixels[$];     // pixels of the item just traced
  int     used_items;
  int     mismatches  = 0;
  int     pixels_seen = 0;
  int     idle_cycles = 0;

  // Input gap rate, and controls shared with the ready driver
  int gap_pct;
  int stall_pct = 0;
  bit calm      = 1'b0;
  bit hold_req  = 1'b0;

  task automatic report_mismatch(input string what, input logic [79:0] got,
                                 input logic [79:0] want);
    mismatches++;
    $display("MISMATCH %s: got 0x%0h, want 0x%0h", what, got, want);
  endtask

  // Clip against the screen and queue one pixel; a and b are major/minor axis
  function automatic void place_pixel(input longint a, input longint b,
                                      input logic [alr_pkg::COLOR_W-1:0] color,
                                      input longint w, input bit done);
    longint x, y, bw, bh;
    pixel_t p;
    x  = ln_steep ? b : a;
    y  = ln_steep ? a : b;
    bw = (longint'(scr_w) > longint'(alr_pkg::SCREEN_MAX)) ? longint'(alr_pkg::SCREEN_MAX)
                                                           : longint'(scr_w);
    bh = (longint'(scr_h) > longint'(alr_pkg::SCREEN_MAX)) ? longint'(alr_pkg::SCREEN_MAX)
                                                           : longint'(scr_h);
    if (x < 0 || y < 0 || x >= bw || y >= bh) return;
    p.px   = x[alr_pkg::PIX_W-1:0];
    p.py   = y[alr_pkg::PIX_W-1:0];
    p.ofs  = alr_pkg::OFS_W'(y * longint'(row_stride) + x * longint'(pix_bits / 8));
    p.b    = alr_pkg::CH_W'((longint'(color[7:0]) * w) >> alr_pkg::FRAC_BITS);
    p.g    = alr_pkg::CH_W'((longint'(color[15:8]) * w) >> alr_pkg::FRAC_BITS);
    p.r    = alr_pkg::CH_W'((longint'(color[23:16]) * w) >> alr_pkg::FRAC_BITS);
    p.last = 1'b0;
    p.done = done;
    item_pixels.push_back(p);
  endfunction

  // Trace one accepted item and queue the pixel writes it causes
  function automatic void trace_line_item(input line_item_t it);
    longint x1, y1, x2, y2, t, dx, dy, f, ip;
    logic [alr_pkg::COLOR_W-1:0] c1, c2;
    bit single, done;
    item_pixels.delete();
    if (it.op == alr_pkg::OP_START) begin
      used_items++;
      x1 = longint'($signed(it.sx));
      y1 = longint'($signed(it.sy));
      x2 = longint'($signed(it.ex));
      y2 = longint'($signed(it.ey));
      c1 = (it.sc == '0) ? fallback : it.sc;
      c2 = (it.ec == '0) ? fallback : it.ec;
      dx = (x2 > x1) ? x2 - x1 : x1 - x2;
      dy = (y2 > y1) ? y2 - y1 : y1 - y2;
      ln_steep = dy > dx;
      if (ln_steep) begin
        t = x1; x1 = y1; y1 = t;
        t = x2; x2 = y2; y2 = t;
      end
      // ordering moves coordinates only, colours stay with start and end
      if (x1 > x2) begin
        t = x1; x1 = x2; x2 = t;
        t = y1; y1 = y2; y2 = t;
      end
      dx          = x2 - x1;
      dy          = y2 - y1;
      single      = (dx == 0);
      ln_slope    = single ? 0 : (dy * UNIT_WEIGHT) / dx;
      ln_row      = y1 * UNIT_WEIGHT + ln_slope;
      ln_col      = x1 + 1;
      ln_last_col = x2;
      ln_color    = c2;
      ln_busy     = !single;
      place_pixel(x1, y1, c1, UNIT_WEIGHT, single);
      place_pixel(x2, y2, c2, UNIT_WEIGHT, single);
    end else if (ln_busy) begin
      used_items++;
      f    = ln_row & (UNIT_WEIGHT - 1);
      ip   = (ln_row - f) / UNIT_WEIGHT;
      done = ln_col >= ln_last_col;
      if (UNIT_WEIGHT - f != 0) place_pixel(ln_col, ip, ln_color, UNIT_WEIGHT - f, done);
      if (f != 0) place_pixel(ln_col, ip + 1, ln_color, f, done);
      ln_row += ln_slope;
      ln_col += 1;
      if (done) ln_busy = 1'b0;
    end
    if (item_pixels.size() > 0) item_pixels[item_pixels.size() - 1].last = 1'b1;
    foreach (item_pixels[i]) expected_pixels.push_back(item_pixels[i]);
  endfunction

  // Offer one item, hold it until the transfer, then trace it
  task automatic send_item(input line_item_t it);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.op          <= it.op;
    in_bus.start_x     <= it.sx;
    in_bus.start_y     <= it.sy;
    in_bus.start_color <= it.sc;
    in_bus.end_x       <= it.ex;
    in_bus.end_y       <= it.ey;
    in_bus.end_color   <= it.ec;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    trace_line_item(it);
  endtask

  // Wait for every pending pixel, then let a silent start finish
  task automatic settle_block();
    in_bus.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [alr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [alr_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      alr_pkg::CFG_SCREEN_WIDTH:  scr_w      = data[alr_pkg::SCR_W-1:0];
      alr_pkg::CFG_SCREEN_HEIGHT: scr_h      = data[alr_pkg::SCR_W-1:0];
      alr_pkg::CFG_ROW_STRIDE:    row_stride = data[alr_pkg::STRIDE_W-1:0];
      alr_pkg::CFG_BITS_PER_PIX:  pix_bits   = data[alr_pkg::BPP_W-1:0];
      alr_pkg::CFG_FALLBACK:      fallback   = data[alr_pkg::COLOR_W-1:0];
      default: ;
    endcase
  endtask

  // Register value, with random junk above the register width when dirty
  function automatic logic [alr_pkg::CFG_DATA_W-1:0] pad_reg(input longint value,
                                                             input int width,
                                                             input bit dirty);
    logic [alr_pkg::CFG_DATA_W-1:0] mask;
    mask = alr_pkg::CFG_DATA_W'((longint'(1) << width) - 1);
    return dirty ? ((alr_pkg::CFG_DATA_W'($urandom) & ~mask)
                    | (alr_pkg::CFG_DATA_W'(value) & mask))
                 : alr_pkg::CFG_DATA_W'(value);
  endfunction

  // Output ready: random stall bursts, one long hold-off on request
  initial begin : drive_ready
    int stall_left;
    bit hold_taken;
    stall_left = 0;
    hold_taken = 1'b0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_taken && !calm) begin
        hold_taken = 1'b1;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 18);
      end
      out_bus.ready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // Check each pixel transfer against the oldest expected pixel
  always @(posedge clk_i) begin : check_pixels
    pixel_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("pixel with nothing expected",
                        {out_bus.pixel_x, out_bus.pixel_y, out_bus.byte_offset}, '0);
      end else begin
        want = expected_pixels.pop_front();
        if (out_bus.pixel_x != want.px)
          report_mismatch($sformatf("pixel %0d x", pixels_seen), out_bus.pixel_x, want.px);
        if (out_bus.pixel_y != want.py)
          report_mismatch($sformatf("pixel %0d y", pixels_seen), out_bus.pixel_y, want.py);
        if (out_bus.byte_offset != want.ofs)
          report_mismatch($sformatf("pixel %0d byte_offset", pixels_seen),
                          out_bus.byte_offset, want.ofs);
        if (out_bus.blue != want.b)
          report_mismatch($sformatf("pixel %0d blue", pixels_seen), out_bus.blue, want.b);
        if (out_bus.green != want.g)
          report_mismatch($sformatf("pixel %0d green", pixels_seen), out_bus.green, want.g);
        if (out_bus.red != want.r)
          report_mismatch($sformatf("pixel %0d red", pixels_seen), out_bus.red, want.r);
        if (out_bus.last != want.last)
          report_mismatch($sformatf("pixel %0d last", pixels_seen), out_bus.last, want.last);
        if (out_bus.line_done != want.done)
          report_mismatch($sformatf("pixel %0d line_done", pixels_seen),
                          out_bus.line_done, want.done);
      end
      pixels_seen++;
    end
  end

  // Watchdog: too long without any transfer on either channel
  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    line_item_t            it;
    longint                bw, bh, x1, y1, len, nsteps;
    longint                w, h, st, bp, fb;
    int                    quota;
    bit                    wild, dirty;

    in_bus.valid       <= 1'b0;
    in_bus.op          <= alr_pkg::OP_START;
    in_bus.start_x     <= '0;
    in_bus.start_y     <= '0;
    in_bus.start_color <= '0;
    in_bus.end_x       <= '0;
    in_bus.end_y       <= '0;
    in_bus.end_color   <= '0;
    scr_w       = alr_pkg::RST_SCREEN_WIDTH;
    scr_h       = alr_pkg::RST_SCREEN_HEIGHT;
    row_stride  = alr_pkg::RST_ROW_STRIDE;
    pix_bits    = alr_pkg::RST_BITS_PER_PIX;
    fallback    = alr_pkg::RST_FALLBACK;
    ln_busy     = 1'b0;
    ln_steep    = 1'b0;
    ln_col      = 0;
    ln_last_col = 0;
    ln_row      = 0;
    ln_slope    = 0;
    ln_color    = '0;
    used_items  = 0;
    gap_pct     = 0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table at the reset configuration
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_item(DIR_TAB[i].it);
      if (DIR_TAB[i].chk) begin
        if (item_pixels.size() == 0)
          report_mismatch($sformatf("directed row %0d no pixel", i), '0, DIR_TAB[i].want);
        else if (item_pixels[0] != DIR_TAB[i].want)
          report_mismatch($sformatf("directed row %0d first pixel", i),
                          item_pixels[0], DIR_TAB[i].want);
      end
    end

    // Random lines over several screen setups
    for (int ph = 0; ph < PHASES; ph++) begin
      settle_block();
      dirty = ph > 5;
      case (ph)
        0: begin w = 1920; h = 1080; st = 7680; bp = 32; fb = 24'hFF7F00; end
        1: begin w = 64; h = 48; st = 256; bp = 32; fb = $urandom; end
        2: begin w = 1; h = 1; st = 1; bp = 8; fb = 0; end
        3: begin w = 4096; h = 4096; st = 16384; bp = 32; fb = 24'hFFFFFF; end
        4: begin w = 8191; h = 8191; st = 32767; bp = 63; fb = $urandom; end
        5: begin w = 0; h = 0; st = $urandom; bp = $urandom; fb = $urandom; end
        default: begin
          w  = $urandom_range(1, 400);
          h  = $urandom_range(1, 300);
          st = $urandom_range(0, 32767);
          bp = $urandom_range(0, 63);
          fb = $urandom;
        end
      endcase
      write_reg(alr_pkg::CFG_SCREEN_WIDTH, pad_reg(w, alr_pkg::SCR_W, dirty));
      write_reg(alr_pkg::CFG_SCREEN_HEIGHT, pad_reg(h, alr_pkg::SCR_W, dirty));
      write_reg(alr_pkg::CFG_ROW_STRIDE, pad_reg(st, alr_pkg::STRIDE_W, dirty));
      write_reg(alr_pkg::CFG_BITS_PER_PIX, pad_reg(bp, alr_pkg::BPP_W, dirty));
      write_reg(alr_pkg::CFG_FALLBACK, pad_reg(fb, alr_pkg::COLOR_W, dirty));
      // indexes past the last register must be ignored
      if (ph == 4)
        for (int k = alr_pkg::CFG_FALLBACK + 1; k < 2 ** alr_pkg::CFG_IDX_W; k++)
          write_reg(alr_pkg::CFG_IDX_W'(k), alr_pkg::CFG_DATA_W'($urandom));

      gap_pct   = (ph == 1) ? 0 : (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 30 : 10;
      stall_pct <= (ph % 4 == 2) ? 0 : (ph % 4 == 3) ? 30 : 12;
      if (ph == 1) hold_req <= 1'b1;   // fill the block behind a stalled output
      if (ph == PHASES - 1) begin
        calm    <= 1'b1;
        gap_pct = 0;
      end
      quota      = (ph == 5) ? 60 : 175;
      bw         = (longint'(scr_w) > longint'(alr_pkg::SCREEN_MAX))
                   ? longint'(alr_pkg::SCREEN_MAX) : longint'(scr_w);
      bh         = (longint'(scr_h) > longint'(alr_pkg::SCREEN_MAX))
                   ? longint'(alr_pkg::SCREEN_MAX) : longint'(scr_h);
      if (bw == 0) bw = 32;
      if (bh == 0) bh = 32;
      used_items = 0;

      while (used_items < quota) begin
        // a start around the screen, now and then anywhere in the coordinate range
        wild  = ($urandom_range(0, 9) == 0);
        it.op = alr_pkg::OP_START;
        it.sc = ($urandom_range(0, 7) == 0) ? '0 : alr_pkg::COLOR_W'($urandom);
        it.ec = ($urandom_range(0, 7) == 0) ? '0 : alr_pkg::COLOR_W'($urandom);
        if (wild) begin
          it.sx = alr_pkg::COORD_BITS'($urandom);
          it.sy = alr_pkg::COORD_BITS'($urandom);
          it.ex = alr_pkg::COORD_BITS'($urandom);
          it.ey = alr_pkg::COORD_BITS'($urandom);
        end else begin
          len   = ($urandom_range(0, 15) == 0) ? longint'($urandom_range(0, 200))
                                               : longint'($urandom_range(0, 20));
          x1    = longint'($urandom_range(0, bw + 11)) - 6;
          y1    = longint'($urandom_range(0, bh + 11)) - 6;
          it.sx = alr_pkg::COORD_BITS'(x1);
          it.sy = alr_pkg::COORD_BITS'(y1);
          it.ex = alr_pkg::COORD_BITS'(x1 + longint'($urandom_range(0, 2 * len)) - len);
          it.ey = alr_pkg::COORD_BITS'(y1 + longint'($urandom_range(0, 2 * len)) - len);
        end
        send_item(it);

        // steps to the end of the line; sometimes cut short or run past the end
        nsteps = ln_busy ? ln_last_col - ln_col + 1 : 0;
        if (wild && nsteps > 4) nsteps = longint'($urandom_range(1, 4));
        else if ($urandom_range(0, 7) == 0) nsteps = longint'($urandom_range(0, nsteps));
        if ($urandom_range(0, 9) == 0) nsteps += longint'($urandom_range(1, 2));
        for (longint k = 0; k < nsteps; k++) begin
          it.op = alr_pkg::OP_STEP;
          it.sx = alr_pkg::COORD_BITS'($urandom);
          it.sy = alr_pkg::COORD_BITS'($urandom);
          it.sc = alr_pkg::COLOR_W'($urandom);
          it.ex = alr_pkg::COORD_BITS'($urandom);
          it.ey = alr_pkg::COORD_BITS'($urandom);
          it.ec = alr_pkg::COLOR_W'($urandom);
          send_item(it);
        end
      end
    end

    settle_block();
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[antialiased_line_rasterizer_unit.f]
rtl/alr_pkg.sv
rtl/alr_in_if.sv
rtl/alr_out_if.sv
rtl/alr_ctrl.sv
rtl/alr_div.sv
rtl/alr_datapath.sv
rtl/antialiased_line_rasterizer_unit.sv
sim/antialiased_line_rasterizer_unit_tb.sv
